// ===== rtl/core/ssp_pkg.sv =====
package ssp_pkg;

    localparam int COUNT_BITS      = 5;
    localparam int NODE_BITS       = 4;
    localparam int WEIGHT_IN_BITS  = 16;
    localparam int DIST_OUT_BITS   = 20;
    localparam int RESULT_LIMIT    = 16;
    localparam int DEF_MAX_NODES   = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic [COUNT_BITS-1:0]    COUNT_RESET  = 5'd16;
    localparam logic [DIST_OUT_BITS-1:0] DIST_OUT_MAX = 20'hFFFFF;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

endpackage

// ===== rtl/core/ssp_in_if.sv =====
interface ssp_in_if;
    import ssp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [NODE_BITS-1:0]      row;
    logic [NODE_BITS-1:0]      col;
    logic [WEIGHT_IN_BITS-1:0] weight;
    logic [NODE_BITS-1:0]      src_node;

    modport source (output valid, mode, row, col, weight, src_node, input ready);
    modport sink   (input valid, mode, row, col, weight, src_node, output ready);
endinterface

// ===== rtl/core/ssp_out_if.sv =====
interface ssp_out_if;
    import ssp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [NODE_BITS-1:0]     node;
    logic [DIST_OUT_BITS-1:0] distance;
    logic                     reachable;
    logic                     last;

    modport source (output valid, node, distance, reachable, last, input ready);
    modport sink   (input valid, node, distance, reachable, last, output ready);
endinterface

// ===== rtl/core/ssp_wmem.sv =====
module ssp_wmem #(
    parameter int AW = 8,
    parameter int WB = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [WB-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [WB-1:0] o_rdata_a,
    output logic [WB-1:0] o_rdata_b
);
    localparam int DEPTH = 1 << AW;

    logic [WB-1:0] r_mem [DEPTH];
    logic [WB-1:0] r_rdata_a;
    logic [WB-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

// ===== rtl/core/ssp_cell.sv =====
module ssp_cell #(
    parameter int IW  = 4,
    parameter int DB  = 21,
    parameter int WB  = 16,
    parameter int IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic [1+1+IW+DB-1:0]    i_tok,
    input  logic [IW+DB+WB-1:0]     i_bc,
    output logic [1+1+IW+DB-1:0]    o_tok,
    output logic [1+DB-1:0]         o_st
);
    // running minimum traveling down the chain
    typedef struct packed {
        logic          active;
        logic          found;
        logic [IW-1:0] idx;
        logic [DB-1:0] cost;
    } t_tok;

    // settled node of this round and the edge weight to this cell
    typedef struct packed {
        logic [IW-1:0] u;
        logic [DB-1:0] du;
        logic [WB-1:0] w;
    } t_bc;

    typedef struct packed {
        logic          reached;
        logic [DB-1:0] cost;
    } t_cst;

    t_tok          tok_in;
    t_bc           bc;
    t_tok          r_tok;
    t_tok          n_tok;
    t_cst          st;
    logic [DB-1:0] r_dist;
    logic [DB-1:0] n_dist;
    logic          r_reached;
    logic          n_reached;
    logic          r_settled;
    logic          n_settled;
    logic [DB-1:0] cand;

    assign tok_in = i_tok;
    assign bc     = i_bc;
    assign cand   = bc.du + DB'(bc.w);

    always_comb begin
        n_dist    = r_dist;
        n_reached = r_reached;
        n_settled = r_settled;
        n_tok     = tok_in;
        if (tok_in.active) begin
            if (bc.u == IW'(IDX)) begin
                n_settled = 1'b1;
                n_reached = 1'b1;
                n_dist    = bc.du;
            end else if (!r_settled && bc.w != '0 && (!r_reached || cand < r_dist)) begin
                n_dist    = cand;
                n_reached = 1'b1;
            end
            // strict compare keeps the lowest index on ties
            if (n_reached && !n_settled && (!tok_in.found || n_dist < tok_in.cost)) begin
                n_tok.found = 1'b1;
                n_tok.idx   = IW'(IDX);
                n_tok.cost  = n_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= 1'b0;
            r_settled <= 1'b0;
            r_tok     <= '0;
        end else if (i_clear) begin
            r_reached <= 1'b0;
            r_settled <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_reached <= n_reached;
            r_settled <= n_settled;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
    end

    assign st.reached = r_reached;
    assign st.cost    = r_dist;
    assign o_tok      = r_tok;
    assign o_st       = st;
endmodule

// ===== rtl/core/single_source_shortest_paths.sv =====
// Load word: written when taken, next word taken in the following cycle.
// Run word: R rounds before the first result, R being the nodes reached; each round is
// one sweep of the weight store's read ports down the cell chain. Results then leave at
// one word per cycle while o_out is ready, node_count (clamped to 1..CAP) words per run.
// Reset is synchronous; afterwards a pass zeroes the weight store, all
// 4**clog2(MAX_NODES) entries (256 by default), with no input word taken until it ends.
module single_source_shortest_paths #(
    parameter int MAX_NODES   = ssp_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = ssp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssp_pkg::COUNT_BITS-1:0] i_cfg_data,
    ssp_in_if.sink                         i_in,
    ssp_out_if.source                      o_out
);
    import ssp_pkg::*;

    localparam int IW  = $clog2(MAX_NODES);
    localparam int AW  = 2 * IW;
    localparam int DB  = WEIGHT_BITS + $clog2(MAX_NODES) + 1;
    localparam int CAP = (MAX_NODES < RESULT_LIMIT) ? MAX_NODES : RESULT_LIMIT;
    localparam int XW  = (DB > DIST_OUT_BITS) ? DB : DIST_OUT_BITS;
    localparam int TW  = 2 + IW + DB;

    typedef struct packed {
        logic          active;
        logic          found;
        logic [IW-1:0] idx;
        logic [DB-1:0] cost;
    } t_tok;

    typedef struct packed {
        logic [IW-1:0]          u;
        logic [DB-1:0]          du;
        logic [WEIGHT_BITS-1:0] w;
    } t_bc;

    typedef struct packed {
        logic          reached;
        logic [DB-1:0] cost;
    } t_cst;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_START,
        S_SWEEP,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [COUNT_BITS-1:0]    r_node_count;
    logic [COUNT_BITS-1:0]    r_n;
    logic [NODE_BITS-1:0]     r_src;
    logic [AW-1:0]            r_clr;
    logic [IW-1:0]            r_u;
    logic [DB-1:0]            r_du;
    logic [IW-1:0]            r_k;
    logic                     r_go;
    logic                     r_use;
    logic [COUNT_BITS-1:0]    r_j;
    logic                     r_ovalid;
    logic [NODE_BITS-1:0]     r_onode;
    logic [DIST_OUT_BITS-1:0] r_odist;
    logic                     r_oreach;
    logic                     r_olast;

    logic                   in_fire;
    logic                   load_ok;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;
    logic [WEIGHT_BITS-1:0] rd_a;
    logic [WEIGHT_BITS-1:0] rd_b;
    logic [WEIGHT_BITS-1:0] w_edge;
    logic [COUNT_BITS-1:0]  n_clamp;
    logic                   cell_clear;
    logic                   out_free;
    t_bc                    bc;
    t_tok                   tok_head;
    t_tok                   tok_tail;
    t_cst                   st_sel;
    logic [DIST_OUT_BITS-1:0] dist_sat;
    logic [TW-1:0]          tok_chain [MAX_NODES+1];
    logic [1+DB-1:0]        cell_st   [MAX_NODES];

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign cell_clear = in_fire && (i_in.mode == MODE_RUN);
    assign load_ok    = (32'(i_in.row) < 32'(MAX_NODES)) && (32'(i_in.col) < 32'(MAX_NODES));
    assign out_free   = !r_ovalid || o_out.ready;

    always_comb begin
        if (r_node_count == '0) begin
            n_clamp = COUNT_BITS'(1);
        end else if (32'(r_node_count) > 32'(CAP)) begin
            n_clamp = COUNT_BITS'(CAP);
        end else begin
            n_clamp = r_node_count;
        end
    end

    // weight store: zeroing pass after reset, then loads
    always_comb begin
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = in_fire && (i_in.mode == MODE_LOAD) && load_ok;
            mem_waddr = {IW'(i_in.row), IW'(i_in.col)};
            mem_wdata = WEIGHT_BITS'(i_in.weight);
        end
    end

    ssp_wmem #(
        .AW (AW),
        .WB (WEIGHT_BITS)
    ) u_wmem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a ({r_u, r_k}),
        .i_raddr_b ({r_k, r_u}),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // undirected edge: smaller nonzero of the two entries, none past the nodes in use
    always_comb begin
        if (!r_use) begin
            w_edge = '0;
        end else if (rd_a == '0) begin
            w_edge = rd_b;
        end else if (rd_b == '0) begin
            w_edge = rd_a;
        end else begin
            w_edge = (rd_a < rd_b) ? rd_a : rd_b;
        end
    end

    assign bc.u  = r_u;
    assign bc.du = r_du;
    assign bc.w  = w_edge;

    assign tok_head.active = r_go;
    assign tok_head.found  = 1'b0;
    assign tok_head.idx    = '0;
    assign tok_head.cost   = '0;
    assign tok_chain[0]    = tok_head;

    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        ssp_cell #(
            .IW  (IW),
            .DB  (DB),
            .WB  (WEIGHT_BITS),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (cell_clear),
            .i_tok   (tok_chain[g]),
            .i_bc    (bc),
            .o_tok   (tok_chain[g+1]),
            .o_st    (cell_st[g])
        );
    end

    assign tok_tail = tok_chain[MAX_NODES];
    assign st_sel   = cell_st[IW'(r_j)];

    always_comb begin
        if (XW'(st_sel.cost) > XW'(DIST_OUT_MAX)) begin
            dist_sat = DIST_OUT_MAX;
        end else begin
            dist_sat = DIST_OUT_BITS'(st_sel.cost);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_node_count <= COUNT_RESET;
            r_clr        <= '0;
            r_go         <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            r_go  <= (r_state == S_SWEEP) && (r_k == '0);
            r_use <= (32'(r_k) < 32'(r_n));
            if (r_ovalid && o_out.ready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cell_clear) begin
                        r_n     <= n_clamp;
                        r_src   <= i_in.src_node;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_j <= '0;
                    if ({1'b0, r_src} >= r_n) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_u     <= IW'(r_src);
                        r_du    <= '0;
                        r_k     <= '0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_k <= r_k + IW'(1);
                    if (r_k == IW'(MAX_NODES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (tok_tail.active) begin
                        if (tok_tail.found) begin
                            r_u     <= tok_tail.idx;
                            r_du    <= tok_tail.cost;
                            r_k     <= '0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_j     <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_onode  <= NODE_BITS'(r_j);
                        r_odist  <= st_sel.reached ? dist_sat : '0;
                        r_oreach <= st_sel.reached;
                        r_olast  <= (r_j == r_n - COUNT_BITS'(1));
                        r_j      <= r_j + COUNT_BITS'(1);
                        if (r_j == r_n - COUNT_BITS'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.node      = r_onode;
    assign o_out.distance  = r_odist;
    assign o_out.reachable = r_oreach;
    assign o_out.last      = r_olast;
endmodule

// ===== tb/tb.sv =====
module tb;
    import ssp_pkg::*;

    localparam int NODES       = DEF_MAX_NODES;
    localparam int IDLE_PCT    = 32;
    // wait after the results have drained before a node count is written
    localparam int LOAD_SETTLE = 4;
    // time for one run at full size, added to the final drain wait
    localparam int RUN_CYCLES  = NODES * (NODES + 2) + 2;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic                      mode;
        logic [NODE_BITS-1:0]      row;
        logic [NODE_BITS-1:0]      col;
        logic [WEIGHT_IN_BITS-1:0] weight;
        logic [NODE_BITS-1:0]      source;
    } t_cmd;

    typedef struct {
        logic [NODE_BITS-1:0]     node;
        logic [DIST_OUT_BITS-1:0] distance;
        logic                     reachable;
        logic                     last;
    } t_path_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [COUNT_BITS-1:0] i_cfg_data;

    ssp_in_if  in_if();
    ssp_out_if out_if();

    single_source_shortest_paths u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor state
    logic [WEIGHT_IN_BITS-1:0] weight_mem [NODES][NODES];
    logic [COUNT_BITS-1:0]     node_count_q;
    t_path_result              expected_paths [$];

    bit           failed;
    bit           idle_on;
    bit           stall_on;
    int           quiet_cycles = 0;
    t_path_result want;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int unsigned active_nodes();
        int unsigned k;
        k = node_count_q;
        if (k < 1) k = 1;
        if (k > NODES) k = NODES;
        return k;
    endfunction

    // undirected edge: the smaller nonzero of the two entries
    function automatic int unsigned link_weight(int unsigned a, int unsigned b);
        int unsigned x;
        int unsigned y;
        x = weight_mem[a][b];
        y = weight_mem[b][a];
        if (x == 0) return y;
        if (y == 0) return x;
        return (x < y) ? x : y;
    endfunction

    task automatic predict_distances(input logic [NODE_BITS-1:0] src);
        int unsigned  n, u, v, i, rnd, w, cand;
        int unsigned  best [NODES];
        bit           closed [NODES];
        bit           seen [NODES];
        bit           found;
        t_path_result r;
        n = active_nodes();
        for (i = 0; i < NODES; i++) begin
            best[i]   = 0;
            closed[i] = 1'b0;
            seen[i]   = 1'b0;
        end
        if (src < n) begin
            seen[src] = 1'b1;
            for (rnd = 0; rnd < n; rnd++) begin
                found = 1'b0;
                u     = 0;
                for (i = 0; i < n; i++) begin
                    if (seen[i] && !closed[i] && (!found || best[i] < best[u])) begin
                        u     = i;
                        found = 1'b1;
                    end
                end
                if (!found) break;
                closed[u] = 1'b1;
                for (v = 0; v < n; v++) begin
                    if (!closed[v]) begin
                        w = link_weight(u, v);
                        if (w != 0) begin
                            cand = best[u] + w;
                            if (!seen[v] || cand < best[v]) begin
                                best[v] = cand;
                                seen[v] = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        for (i = 0; i < n; i++) begin
            r.node      = NODE_BITS'(i);
            r.distance  = !seen[i] ? '0 :
                          (best[i] > DIST_OUT_MAX) ? DIST_OUT_MAX : DIST_OUT_BITS'(best[i]);
            r.reachable = seen[i];
            r.last      = (i + 1 == n);
            expected_paths = {expected_paths, r};
        end
    endtask

    // drive one word, wait for the handshake, then update the prediction
    task automatic send_word(input t_cmd c);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.mode     <= c.mode;
        in_if.row      <= c.row;
        in_if.col      <= c.col;
        in_if.weight   <= c.weight;
        in_if.src_node <= c.source;
        do @(posedge i_clk); while (!in_if.ready);
        if (c.mode == MODE_LOAD) begin
            weight_mem[c.row][c.col] = c.weight;
        end else begin
            predict_distances(c.source);
        end
    endtask

    task automatic send_load(input int unsigned r, input int unsigned c, input int unsigned w);
        t_cmd cmd;
        cmd.mode   = MODE_LOAD;
        cmd.row    = NODE_BITS'(r);
        cmd.col    = NODE_BITS'(c);
        cmd.weight = WEIGHT_IN_BITS'(w);
        cmd.source = NODE_BITS'($urandom);
        send_word(cmd);
    endtask

    task automatic send_run(input int unsigned s);
        t_cmd cmd;
        cmd.mode   = MODE_RUN;
        cmd.row    = NODE_BITS'($urandom);
        cmd.col    = NODE_BITS'($urandom);
        cmd.weight = WEIGHT_IN_BITS'($urandom);
        cmd.source = NODE_BITS'(s);
        send_word(cmd);
    endtask

    task automatic wait_drained(input int tail);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_paths.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [COUNT_BITS-1:0] v);
        wait_drained(LOAD_SETTLE);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        node_count_q = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic test_empty_graph();
        send_run(0);
    endtask

    task automatic test_edge_rules();
        send_load(0, 15, 16'hFFFF);
        send_load(15, 0, 1);           // smaller of the two directions wins
        send_run(0);
        send_load(1, 2, 16'hAAAA);
        send_load(2, 1, 16'h5555);
        send_load(3, 3, 7);            // self loop never shortens anything
        send_load(4, 5, 100);
        send_load(4, 5, 50);           // reload replaces
        send_load(5, 0, 3);
        send_load(6, 7, 9);
        send_load(6, 7, 0);            // removes the edge again
        send_load(2, 0, 4);
        send_run(15);
        send_run(4);
        send_run(6);
    endtask

    task automatic test_node_counts();
        write_node_count(5'd1);
        send_run(0);
        send_run(1);
        write_node_count(5'd0);        // acts as one node
        send_run(0);
        send_run(15);
        write_node_count(5'd5);
        send_run(4);
        send_run(9);                   // source beyond the nodes in use
        write_node_count(5'd31);       // saturates to full size
        send_run(0);
        send_run(15);
        write_node_count(5'd16);
        send_run(15);
        send_run(2);
    endtask

    task automatic random_batch(input int words);
        int unsigned n, r, c, w, sel;
        int          k;
        n = ($urandom_range(3) == 0) ? NODES : $urandom_range(2, 12);
        write_node_count(COUNT_BITS'(n));
        for (k = 0; k < words; k++) begin
            if (k == words - 1 || $urandom_range(99) < 12) begin
                send_run(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1));
            end else begin
                r   = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
                c   = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
                sel = $urandom_range(9);
                if (sel < 3) begin
                    w = 0;
                end else if (sel == 3) begin
                    w = $urandom_range(65535);
                end else begin
                    w = $urandom_range(1, 40);
                end
                send_load(r, c, w);
            end
        end
    endtask

    task automatic test_random_graphs();
        repeat (7) random_batch(24);
    endtask

    task automatic test_no_idle_stretch();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        repeat (2) random_batch(24);
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // sender holds off until every pending word has come back, then resumes
    task automatic test_drain_pause();
        send_load(1, 3, 12);
        send_load(3, 8, 5);
        send_run(1);
        send_run(8);
        wait_drained(0);
        send_run(3);
        send_load(1, 8, 2);
        send_run(1);
        send_run(0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_paths.size() == 0) begin
                $error("unexpected word: node %0d distance %0d", out_if.node, out_if.distance);
                failed = 1'b1;
            end else begin
                want = expected_paths.pop_front();
                if (out_if.node !== want.node) begin
                    $error("node: expected %0d, got %0d", want.node, out_if.node);
                    failed = 1'b1;
                end
                if (out_if.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, out_if.distance);
                    failed = 1'b1;
                end
                if (out_if.reachable !== want.reachable) begin
                    $error("reachable: expected %0d, got %0d", want.reachable,
                           out_if.reachable);
                    failed = 1'b1;
                end
                if (out_if.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_if.last);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        failed         = 1'b0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.mode     = MODE_LOAD;
        in_if.row      = '0;
        in_if.col      = '0;
        in_if.weight   = '0;
        in_if.src_node = '0;
        node_count_q   = COUNT_RESET;
        for (int a = 0; a < NODES; a++) begin
            for (int b = 0; b < NODES; b++) begin
                weight_mem[a][b] = '0;
            end
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_graph();
        test_edge_rules();
        test_node_counts();
        test_random_graphs();
        test_no_idle_stretch();
        test_drain_pause();

        wait_drained(RUN_CYCLES + 20);
        if (!failed && expected_paths.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
